/* hdl/prgt_pkg.sv */
package prgt_pkg;

    // Field widths of the point stream.
    localparam int unsigned COORD_W  = 32;
    localparam int unsigned COEF_W   = 16;
    localparam int unsigned RING_W   = 16;
    localparam int unsigned REFL_W   = 8;
    localparam int unsigned LINE_W   = 2;
    localparam int unsigned LIMIT_W  = 48;
    localparam int unsigned ROW_W    = 3 * COEF_W;

    // Products and sums inside the pipeline.
    localparam int unsigned PROD_W   = COEF_W + COORD_W;
    localparam int unsigned ACC_W    = PROD_W + 2;
    localparam int unsigned FRAC_CUT = 14;
    localparam int unsigned QUOT_W   = ACC_W - FRAC_CUT;
    localparam int unsigned SQ_W     = 2 * COORD_W;

    // Stream packing.
    localparam int unsigned S_TDATA_W = 160;
    localparam int unsigned M_TDATA_W = 128;

    // Configuration port.
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 6;

    // Register indexes, taken from the byte address divided by eight.
    typedef enum logic [2:0] {
        CFG_ROT_X  = 3'd0,
        CFG_ROT_Y  = 3'd1,
        CFG_ROT_Z  = 3'd2,
        CFG_SHIFT_X = 3'd3,
        CFG_SHIFT_Y = 3'd4,
        CFG_SHIFT_Z = 3'd5,
        CFG_NEAR   = 3'd6,
        CFG_FAR    = 3'd7
    } cfg_index_t;

    // Reset values: identity rotation, no translation, default range band.
    localparam logic [ROW_W-1:0]   ROT_X_RESET = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0]   ROT_Y_RESET = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0]   ROT_Z_RESET = 48'h4000_0000_0000;
    localparam logic [LIMIT_W-1:0] NEAR_RESET  = 48'd8028;
    localparam logic [LIMIT_W-1:0] FAR_RESET   = 48'd943718400;

    // Rounding constant for the drop from 2^-30 to 2^-16 units.
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(signed'(8192));

    localparam logic [REFL_W-1:0] REFL_MAX = 8'd255;

endpackage

/* hdl/point_range_gate_and_rigid_transform_top.sv */
// Point range gate and rigid transform. Each transfer on the slave stream carries one lidar
// point; one result transfer leaves the master stream for every point, with tuser high when
// the point was kept. A point is dropped (tuser low, all data zero) when it is not finite or
// its squared range falls outside the inclusive band [near, far]. Kept points are rotated by
// the Q2.14 matrix, translated, rounded half up to Q15.16 and saturated; the ring offset is
// added modulo 65536 and the intensity is clamped to an 8-bit reflectivity. The block takes
// one point per clock cycle except while the pipeline holds; each point passes a multiply stage,
// a sum stage and a compare and saturate stage that is also the output register. The whole
// pipeline holds while a result waits on the master side. Registers lie at byte address 8*i on the
// 64-bit configuration port; the user must write them only while the block is idle, which it does not enforce.
module point_range_gate_and_rigid_transform_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // Slave stream. tdata from bit 0: pos_x, pos_y, pos_z, brightness, ring_index,
    // ring_shift. tuser: coords_finite.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [prgt_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    input  logic [0:0]                          s_axis_tuser,
    // Master stream. tdata from bit 0: out_x, out_y, out_z, ring_out, scan_line,
    // reflectivity, zero fill. tuser: kept.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [prgt_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic [0:0]                          m_axis_tuser,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [prgt_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [prgt_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [prgt_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import prgt_pkg::*;

    // Configuration registers.
    logic [ROW_W-1:0]          rot_reg   [3];
    logic signed [COORD_W-1:0] shift_reg [3];
    logic [LIMIT_W-1:0]        near_reg;
    logic [LIMIT_W-1:0]        far_reg;
    logic                      cfg_write;
    cfg_index_t                cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = cfg_index_t'(paddr[CFG_ADDR_W-1:3]);

    // Register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0]   <= ROT_X_RESET;
            rot_reg[1]   <= ROT_Y_RESET;
            rot_reg[2]   <= ROT_Z_RESET;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
            near_reg     <= NEAR_RESET;
            far_reg      <= FAR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ROT_X:   rot_reg[0]   <= pwdata[ROW_W-1:0];
                CFG_ROT_Y:   rot_reg[1]   <= pwdata[ROW_W-1:0];
                CFG_ROT_Z:   rot_reg[2]   <= pwdata[ROW_W-1:0];
                CFG_SHIFT_X: shift_reg[0] <= pwdata[COORD_W-1:0];
                CFG_SHIFT_Y: shift_reg[1] <= pwdata[COORD_W-1:0];
                CFG_SHIFT_Z: shift_reg[2] <= pwdata[COORD_W-1:0];
                CFG_NEAR:    near_reg     <= pwdata[LIMIT_W-1:0];
                CFG_FAR:     far_reg      <= pwdata[LIMIT_W-1:0];
                default:     ;
            endcase
        end
    end

    // Register read.
    always_comb
    begin
        unique case (cfg_index)
            CFG_ROT_X:   prdata = CFG_DATA_W'(rot_reg[0]);
            CFG_ROT_Y:   prdata = CFG_DATA_W'(rot_reg[1]);
            CFG_ROT_Z:   prdata = CFG_DATA_W'(rot_reg[2]);
            CFG_SHIFT_X: prdata = CFG_DATA_W'(unsigned'(shift_reg[0]));
            CFG_SHIFT_Y: prdata = CFG_DATA_W'(unsigned'(shift_reg[1]));
            CFG_SHIFT_Z: prdata = CFG_DATA_W'(unsigned'(shift_reg[2]));
            CFG_NEAR:    prdata = CFG_DATA_W'(near_reg);
            CFG_FAR:     prdata = CFG_DATA_W'(far_reg);
            default:     prdata = '0;
        endcase
    end

    // The pipeline advances as one whenever the output register is free or being emptied.
    logic advance;
    logic in_xfer;
    logic v1_reg, v2_reg, v3_reg;

    assign advance       = !v3_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign in_xfer       = s_axis_tvalid & s_axis_tready;

    // Input unpacking.
    logic signed [COORD_W-1:0] pos [3];
    logic signed [COORD_W-1:0] brightness;
    logic [RING_W-1:0]         ring_index;
    logic [RING_W-1:0]         ring_shift;
    logic                      coords_finite;

    assign pos[0]        = s_axis_tdata[31:0];
    assign pos[1]        = s_axis_tdata[63:32];
    assign pos[2]        = s_axis_tdata[95:64];
    assign brightness    = s_axis_tdata[127:96];
    assign ring_index    = s_axis_tdata[143:128];
    assign ring_shift    = s_axis_tdata[159:144];
    assign coords_finite = s_axis_tuser[0];

    // Stage 1: squares for the range test, the nine matrix products, ring and reflectivity.
    logic [SQ_W-1:0]          sq_next   [3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic [REFL_W-1:0]        refl_next;
    logic [RING_W-1:0]        ring1_next;

    logic [SQ_W-1:0]          sq_reg    [3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic [REFL_W-1:0]        refl1_reg;
    logic [RING_W-1:0]        ring1_reg;
    logic                     fin1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = unsigned'(SQ_W'(pos[i] * pos[i]));
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i][j] = signed'(rot_reg[i][COEF_W*j +: COEF_W]) * pos[j];
            end
        end
    end

    // Integer part of the intensity, clamped to the 8-bit range.
    always_comb
    begin
        if (brightness[COORD_W-1])
            refl_next = '0;
        else if (brightness[COORD_W-2:16+REFL_W] != '0)
            refl_next = REFL_MAX;
        else
            refl_next = brightness[16+REFL_W-1:16];
    end

    assign ring1_next = ring_index + ring_shift;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_reg    <= sq_next;
            prod_reg  <= prod_next;
            refl1_reg <= refl_next;
            ring1_reg <= ring1_next;
            fin1_reg  <= coords_finite;
        end
    end

    // Stage 2: squared range modulo 2^64 and the rounded accumulator of each row.
    logic [SQ_W-1:0]          r2_next;
    logic signed [ACC_W-1:0]  acc_next [3];

    logic [SQ_W-1:0]          r2_reg;
    logic signed [ACC_W-1:0]  acc_reg  [3];
    logic [REFL_W-1:0]        refl2_reg;
    logic [RING_W-1:0]        ring2_reg;
    logic                     fin2_reg;

    assign r2_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = ACC_W'(prod_reg[i][0]) + ACC_W'(prod_reg[i][1])
                        + ACC_W'(prod_reg[i][2])
                        + signed'({{(ACC_W-COORD_W-FRAC_CUT){shift_reg[i][COORD_W-1]}},
                                   shift_reg[i], {FRAC_CUT{1'b0}}})
                        + ROUND_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r2_reg    <= r2_next;
            acc_reg   <= acc_next;
            refl2_reg <= refl1_reg;
            ring2_reg <= ring1_reg;
            fin2_reg  <= fin1_reg;
        end
    end

    // Stage 3: range gate, floor shift with saturation, zeroing of dropped points.
    logic                      keep_next;
    logic signed [QUOT_W-1:0]  quot [3];
    logic [COORD_W-1:0]        coord_next [3];
    logic [M_TDATA_W-1:0]      tdata_next;
    logic [M_TDATA_W-1:0]      tdata_reg;
    logic                      kept_reg;

    assign keep_next = fin2_reg
                     && !(r2_reg < {near_reg, 16'd0})
                     && !(r2_reg > {far_reg, 16'd0});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quot[i] = QUOT_W'(acc_reg[i] >>> FRAC_CUT);
            if (quot[i][QUOT_W-1:COORD_W-1] == '0 || quot[i][QUOT_W-1:COORD_W-1] == '1)
                coord_next[i] = quot[i][COORD_W-1:0];
            else if (quot[i][QUOT_W-1])
                coord_next[i] = {1'b1, {(COORD_W-1){1'b0}}};
            else
                coord_next[i] = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        if (keep_next)
            tdata_next = {6'd0, refl2_reg, ring2_reg[LINE_W-1:0], ring2_reg,
                          coord_next[2], coord_next[1], coord_next[0]};
        else
            tdata_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tdata_reg <= tdata_next;
            kept_reg  <= keep_next;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_xfer;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign m_axis_tvalid   = v3_reg;
    assign m_axis_tdata    = tdata_reg;
    assign m_axis_tuser[0] = kept_reg;

    // A dropped point leaves with all of its data zero.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("dropped point carries nonzero data");

    // The scan line always matches the low bits of the output ring.
    a_scan_line: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[113:112] == m_axis_tdata[97:96]))
        else $error("scan line does not follow ring");

    // An accepted point is in stage one on the next cycle.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> v1_reg)
        else $error("accepted point lost at pipeline entry");

    // A held pipeline keeps its stage two contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && v2_reg) |=> (v2_reg && $stable(r2_reg)))
        else $error("stage two changed during a stall");

    // The second stage reaches the output register whenever the pipeline moves.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && v2_reg) |=> m_axis_tvalid)
        else $error("point lost between stage two and output");

endmodule

/* tb/sv/testbench.sv */
module testbench;
    import prgt_pkg::*;

    localparam int unsigned PIPE_DEPTH       = 3;
    localparam int unsigned STALL_LIMIT      = 4000;
    localparam int unsigned RANDOM_PHASES    = 6;
    localparam int unsigned POINTS_PER_PHASE = 310;
    localparam int unsigned REPORT_LIMIT     = 10;

    // One lidar point as it enters the block.
    typedef struct packed {
        logic        finite;
        logic [15:0] ring_shift;
        logic [15:0] ring_index;
        logic [31:0] brightness;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } point_t;

    // One result: tuser on top of the master tdata layout.
    typedef struct packed {
        logic        kept;
        logic [5:0]  fill;
        logic [7:0]  reflectivity;
        logic [1:0]  scan_line;
        logic [15:0] ring_out;
        logic [31:0] out_z;
        logic [31:0] out_y;
        logic [31:0] out_x;
    } result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    // Copy of the register file used for prediction.
    logic [ROW_W-1:0]       row_cfg [3];
    logic [31:0]            shift_cfg [3];
    logic [LIMIT_W-1:0]     near_cfg;
    logic [LIMIT_W-1:0]     far_cfg;

    result_t                pending_results [$];
    int unsigned            mismatch_count = 0;
    int unsigned            stall_cycles = 0;
    int unsigned            send_idle_pct = 25;
    int unsigned            recv_idle_pct = 73;

    point_range_gate_and_rigid_transform_top i_dut (.*);

    // Clock with a period of 8.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge clk)
    begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Work out the result of one point from the register copy.
    function automatic result_t predict_point(input point_t p);
        result_t            r;
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic signed [63:0] pz;
        logic signed [63:0] acc;
        logic signed [63:0] q;
        logic [65:0]        range_sq;
        logic [31:0]        coord_out [3];
        r = '0;
        px = $signed(p.pos_x);
        py = $signed(p.pos_y);
        pz = $signed(p.pos_z);
        if (!p.finite)
            return r;
        // Squared range in 2^-32 units against limits scaled up by 2^16.
        range_sq = px * px + py * py + pz * pz;
        if (range_sq < {2'b00, near_cfg, 16'h0000} || range_sq > {2'b00, far_cfg, 16'h0000})
            return r;
        // Rotate, translate, round half up and saturate each axis.
        for (int i = 0; i < 3; i++)
        begin
            acc = $signed(row_cfg[i][15:0]) * px + $signed(row_cfg[i][31:16]) * py
                + $signed(row_cfg[i][47:32]) * pz + $signed(shift_cfg[i]) * 64'sd16384
                + 64'sd8192;
            q = acc >>> FRAC_CUT;
            if (q > 64'sd2147483647)
                coord_out[i] = 32'h7FFF_FFFF;
            else if (q < -64'sd2147483648)
                coord_out[i] = 32'h8000_0000;
            else
                coord_out[i] = q[31:0];
        end
        r.kept = 1'b1;
        r.out_x = coord_out[0];
        r.out_y = coord_out[1];
        r.out_z = coord_out[2];
        r.ring_out = p.ring_index + p.ring_shift;
        r.scan_line = r.ring_out[1:0];
        if (p.brightness[31])
            r.reflectivity = '0;
        else if (p.brightness[30:16] > 15'd255)
            r.reflectivity = REFL_MAX;
        else
            r.reflectivity = p.brightness[23:16];
        return r;
    endfunction

    function automatic point_t make_point(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic finite,
                                          input logic [31:0] bright, input logic [15:0] ring,
                                          input logic [15:0] shift);
        point_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        p.finite = finite;
        p.brightness = bright;
        p.ring_index = ring;
        p.ring_shift = shift;
        return p;
    endfunction

    // Mostly coordinates within sensor range, with tiny, full-range and edge values mixed in.
    function automatic logic [31:0] random_coord();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return 32'($urandom_range(0, 8388608)) - 32'd4194304;
        if (pick < 80)
            return 32'($urandom_range(0, 2048)) - 32'd1024;
        if (pick < 90)
            return $urandom;
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic point_t random_point();
        point_t      p;
        int unsigned pick;
        p.pos_x = random_coord();
        p.pos_y = random_coord();
        p.pos_z = random_coord();
        p.finite = ($urandom_range(9) != 0);
        pick = $urandom_range(99);
        if (pick < 60)
            p.brightness = $urandom_range(0, 300 * 65536);
        else if (pick < 85)
            p.brightness = $urandom;
        else if (pick < 92)
            p.brightness = 32'h8000_0000;
        else
            p.brightness = 32'h00FF_0000;
        p.ring_index = 16'($urandom);
        p.ring_shift = ($urandom_range(1) == 0) ? 16'h0000 : 16'($urandom);
        return p;
    endfunction

    // Offer one point on the slave stream and record its expected result once accepted.
    task automatic send_point(input point_t p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {p.ring_shift, p.ring_index, p.brightness, p.pos_z, p.pos_y, p.pos_x};
        s_axis_tuser = p.finite;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.insert(pending_results.size(), predict_point(p));
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_until_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 1) @(posedge clk);
    endtask

    // One write transfer on the configuration port, mirrored into the register copy.
    task automatic write_register(input cfg_index_t idx, input logic [63:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        case (idx)
            CFG_ROT_X:   row_cfg[0] = value[ROW_W-1:0];
            CFG_ROT_Y:   row_cfg[1] = value[ROW_W-1:0];
            CFG_ROT_Z:   row_cfg[2] = value[ROW_W-1:0];
            CFG_SHIFT_X: shift_cfg[0] = value[31:0];
            CFG_SHIFT_Y: shift_cfg[1] = value[31:0];
            CFG_SHIFT_Z: shift_cfg[2] = value[31:0];
            CFG_NEAR:    near_cfg = value[LIMIT_W-1:0];
            CFG_FAR:     far_cfg = value[LIMIT_W-1:0];
            default:     ;
        endcase
    endtask

    // Reset configuration: drops, finite flag, ring wrap, reflectivity clamp, far boundary.
    task automatic test_default_fields();
        send_point(make_point(32'h0, 32'h0, 32'h0, 1'b1, 32'h0010_0000, 16'd7, 16'd0));
        send_point(make_point(32'h0001_0000, 32'h0, 32'h0, 1'b0, 32'h0010_0000, 16'd5, 16'd0));
        send_point(make_point(32'h0001_0000, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFF,
                              16'hFFFF, 16'h0001));
        send_point(make_point(32'h0, 32'h0002_0000, 32'h0, 1'b1, 32'h00FF_0000, 16'd3, 16'd0));
        send_point(make_point(32'h0, 32'h0, 32'hFFFB_0000, 1'b1, 32'h7FFF_FFFF,
                              16'h1234, 16'hFFFF));
        send_point(make_point(32'h0078_0000, 32'h0, 32'h0, 1'b1, 32'h0001_0000, 16'd1, 16'd2));
        send_point(make_point(32'h0078_0001, 32'h0, 32'h0, 1'b1, 32'h0001_0000, 16'd1, 16'd2));
        send_point(make_point(32'hFFFF_0000, 32'h0000_8000, 32'h0000_7FFF, 1'b1, 32'h00FE_FFFF,
                              16'h8000, 16'h7FFF));
    endtask

    // Points exactly on and just outside both bounds, then an empty band.
    task automatic test_range_band();
        wait_until_drained();
        write_register(CFG_NEAR, 64'hFFFF_0000_0000_2710);
        write_register(CFG_FAR, 64'h0000_0000_0000_9C40);
        send_point(make_point(32'd25600, 32'h0, 32'h0, 1'b1, 32'h0004_0000, 16'd9, 16'd1));
        send_point(make_point(32'd25599, 32'h0, 32'h0, 1'b1, 32'h0004_0000, 16'd9, 16'd1));
        send_point(make_point(32'd51200, 32'h0, 32'h0, 1'b1, 32'h0004_0000, 16'd9, 16'd1));
        send_point(make_point(32'd51201, 32'h0, 32'h0, 1'b1, 32'h0004_0000, 16'd9, 16'd1));
        send_point(make_point(32'h0, -32'sd51200, 32'h0, 1'b1, 32'h0004_0000, 16'd2, 16'd0));
        send_point(make_point(32'h0, 32'h0, -32'sd25600, 1'b1, 32'h0004_0000, 16'd2, 16'd0));
        wait_until_drained();
        write_register(CFG_NEAR, 64'h0000_0000_0000_9C40);
        write_register(CFG_FAR, 64'h0000_0000_0000_2710);
        send_point(make_point(32'd38400, 32'h0, 32'h0, 1'b1, 32'h0004_0000, 16'd2, 16'd0));
    endtask

    // Widest band, extreme coefficients and shifts, and half-way rounding.
    task automatic test_saturation_and_rounding();
        wait_until_drained();
        write_register(CFG_NEAR, 64'h0);
        write_register(CFG_FAR, 64'h0000_FFFF_FFFF_FFFF);
        write_register(CFG_ROT_X, 64'h0000_7FFF_7FFF_7FFF);
        write_register(CFG_ROT_Y, 64'h0000_8000_8000_8000);
        write_register(CFG_ROT_Z, 64'h0000_0000_0000_2000);
        write_register(CFG_SHIFT_X, 64'h0000_0000_7FFF_FFFF);
        write_register(CFG_SHIFT_Y, 64'h0000_0000_8000_0000);
        write_register(CFG_SHIFT_Z, 64'h0);
        send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0,
                              16'd0, 16'd0));
        send_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0,
                              16'd0, 16'd0));
        send_point(make_point(32'd1, 32'h0, 32'h0, 1'b1, 32'h0, 16'd0, 16'd0));
        send_point(make_point(32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h0, 16'd0, 16'd0));
        send_point(make_point(32'd3, 32'h0, 32'h0, 1'b1, 32'h0, 16'd0, 16'd0));
        send_point(make_point(32'hFFFF_FFFD, 32'h0, 32'h0, 1'b1, 32'h0, 16'd0, 16'd0));
        send_point(make_point(32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 16'd0, 16'd0));
    endtask

    // New random register contents; unused upper bits are filled with noise.
    task automatic program_random_config(input bit widest_band);
        write_register(CFG_ROT_X, {$urandom, $urandom});
        write_register(CFG_ROT_Y, {$urandom, $urandom});
        write_register(CFG_ROT_Z, {$urandom, $urandom});
        write_register(CFG_SHIFT_X, {$urandom, $urandom});
        write_register(CFG_SHIFT_Y, {$urandom, $urandom});
        write_register(CFG_SHIFT_Z, {$urandom, $urandom});
        if (widest_band)
        begin
            write_register(CFG_NEAR, {16'($urandom), 48'h0});
            write_register(CFG_FAR, {16'($urandom), 48'hFFFF_FFFF_FFFF});
        end
        else
        begin
            write_register(CFG_NEAR, {16'($urandom), 48'($urandom_range(0, 1 << 20))});
            write_register(CFG_FAR, {16'($urandom), 48'($urandom_range(1 << 27, 1 << 30))});
        end
    endtask

    // Random points under each idling mode, with a fresh configuration per phase.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_until_drained();
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 73;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            program_random_config(phase == 4);
            repeat (POINTS_PER_PHASE) send_point(random_point());
        end
    endtask

    // Compare each result transfer with the oldest expected result.
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'({m_axis_tuser, m_axis_tdata});
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("Unexpected result transfer: %h", got);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                    begin
                        $display("Result mismatch (expected/actual): kept %0b/%0b x %h/%h",
                                 want.kept, got.kept, want.out_x, got.out_x);
                        $display("    y %h/%h z %h/%h ring %h/%h line %0d/%0d",
                                 want.out_y, got.out_y, want.out_z, got.out_z,
                                 want.ring_out, got.ring_out, want.scan_line, got.scan_line);
                        $display("    refl %0d/%0d fill %h/%h",
                                 want.reflectivity, got.reflectivity, want.fill, got.fill);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || psel || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        row_cfg[0] = ROT_X_RESET;
        row_cfg[1] = ROT_Y_RESET;
        row_cfg[2] = ROT_Z_RESET;
        shift_cfg[0] = '0;
        shift_cfg[1] = '0;
        shift_cfg[2] = '0;
        near_cfg = NEAR_RESET;
        far_cfg = FAR_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_fields();
        test_range_band();
        test_saturation_and_rounding();
        test_random_traffic();
        wait_until_drained();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
